// ===== rtl/pcbe_pkg.sv =====
// Shared types, palette tables and codes for the palette cell bitmap encoder.
`timescale 1ns / 1ps

package pcbe_pkg;

   localparam int PAL_SIZE   = 16;
   localparam int ALT_SIZE   = 8;
   localparam int CELL_PIX   = 32;
   localparam int IDX_W      = 4;
   localparam int PIXCNT_W   = 5;
   localparam int SQ_W       = 16;
   localparam int DIST_W     = 18;
   localparam int COUNT_W    = 5;
   localparam int ROWS_W     = 64;

   // Bit pair codes of the multicolor bitmap
   localparam logic [1:0] CODE_BG    = 2'd0;
   localparam logic [1:0] CODE_SLOT0 = 2'd1;
   localparam logic [1:0] CODE_SLOT1 = 2'd2;
   localparam logic [1:0] CODE_SLOT2 = 2'd3;

   // Palette, packed as {red, green, blue}
   localparam logic [23:0] PAL_RGB [PAL_SIZE] = '{
      24'h000000, 24'hFFFFFF, 24'h68372B, 24'h70A4B2,
      24'h6F3D86, 24'h588D43, 24'h352879, 24'hB8C76F,
      24'h6F4F25, 24'h433900, 24'h9A6759, 24'h444444,
      24'h6C6C6C, 24'h9AD284, 24'h6C5EB5, 24'h959595
   };

   // Variant colors that map straight to a palette index
   localparam logic [23:0] ALT_RGB [ALT_SIZE] = '{
      24'h70A4B2, 24'h7ABFC7, 24'hAAFFEE, 24'h99E6F9,
      24'h959595, 24'hABABAB, 24'hBBBBBB, 24'hD2D2D2
   };

   localparam logic [IDX_W-1:0] ALT_IDX [ALT_SIZE] = '{
      4'd3, 4'd3, 4'd3, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15
   };

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DRAIN,
      S_STORE,
      S_SCAN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             sq_en;
      logic [IDX_W-1:0] entry;
      logic             store;
      logic             scan_en;
      logic [IDX_W-1:0] scan_color;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/pcbe_ctrl.sv =====
// Controller: sequences the palette search, index store, color scan and result emit.
`timescale 1ns / 1ps

module pcbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcbe_pkg::status_type status,
   output pcbe_pkg::cmd_type    cmd
);

   localparam logic [pcbe_pkg::IDX_W-1:0] LAST_ENTRY = pcbe_pkg::IDX_W'(pcbe_pkg::PAL_SIZE - 1);

   pcbe_pkg::state_type         state_ff, state_in;
   logic [pcbe_pkg::IDX_W-1:0]  cnt_ff, cnt_in;

   // State and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcbe_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd            = '0;
      cmd.entry      = cnt_ff;
      cmd.scan_color = cnt_ff;
      req_stall      = 1'b1;
      case (state_ff)
         pcbe_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pcbe_pkg::S_SEARCH;
            end
         end
         pcbe_pkg::S_SEARCH: begin
            cmd.sq_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ENTRY) begin
               state_in = pcbe_pkg::S_DRAIN;
            end
         end
         pcbe_pkg::S_DRAIN: begin
            state_in = pcbe_pkg::S_STORE;
         end
         pcbe_pkg::S_STORE: begin
            cmd.store = 1'b1;
            cnt_in    = '0;
            state_in  = status.last_pixel ? pcbe_pkg::S_SCAN : pcbe_pkg::S_IDLE;
         end
         pcbe_pkg::S_SCAN: begin
            cmd.scan_en = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ENTRY) begin
               state_in = pcbe_pkg::S_EMIT;
            end
         end
         pcbe_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = pcbe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pcbe_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pcbe_datapath.sv =====
// Datapath: distance unit, index store, color presence scan, cell encoder and output register.
`timescale 1ns / 1ps

module pcbe_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  pcbe_pkg::cmd_type               cmd,
   output pcbe_pkg::status_type            status,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   input  logic                            csr_write_enable,
   input  logic [3:0]                      csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pcbe_pkg::ROWS_W-1:0]     rsp_bitmap_rows,
   output logic [7:0]                      rsp_screen_byte,
   output logic [3:0]                      rsp_color_byte,
   output logic                            rsp_cell_fits,
   output logic [pcbe_pkg::COUNT_W-1:0]    rsp_color_count
);

   localparam logic [pcbe_pkg::PIXCNT_W-1:0] LAST_PIX =
      pcbe_pkg::PIXCNT_W'(pcbe_pkg::CELL_PIX - 1);

   // Background register
   logic [3:0] bg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= '0;
      end else if (csr_write_enable) begin
         bg_ff <= csr_write_data;
      end
   end

   // Pixel capture
   logic [7:0] pr_ff, pg_ff, pb_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pr_ff <= req_red;
         pg_ff <= req_green;
         pb_ff <= req_blue;
      end
   end

   // Exact match against the variant table
   logic                        alt_hit;
   logic [pcbe_pkg::IDX_W-1:0]  alt_idx;
   always_comb begin
      alt_hit = 1'b0;
      alt_idx = '0;
      for (int i = pcbe_pkg::ALT_SIZE - 1; i >= 0; i--) begin
         if (pcbe_pkg::ALT_RGB[i] == {pr_ff, pg_ff, pb_ff}) begin
            alt_hit = 1'b1;
            alt_idx = pcbe_pkg::ALT_IDX[i];
         end
      end
   end

   // Squaring stage: one palette entry per cycle
   logic [23:0] pal_sel;
   logic [7:0]  dr, dg, db;
   assign pal_sel = pcbe_pkg::PAL_RGB[cmd.entry];
   assign dr = (pr_ff > pal_sel[23:16]) ? pr_ff - pal_sel[23:16] : pal_sel[23:16] - pr_ff;
   assign dg = (pg_ff > pal_sel[15:8])  ? pg_ff - pal_sel[15:8]  : pal_sel[15:8]  - pg_ff;
   assign db = (pb_ff > pal_sel[7:0])   ? pb_ff - pal_sel[7:0]   : pal_sel[7:0]   - pb_ff;

   logic [pcbe_pkg::SQ_W-1:0]  sqr_ff, sqg_ff, sqb_ff;
   logic [pcbe_pkg::IDX_W-1:0] sq_idx_ff;
   logic                       sq_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.sq_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         sqr_ff    <= pcbe_pkg::SQ_W'(dr) * pcbe_pkg::SQ_W'(dr);
         sqg_ff    <= pcbe_pkg::SQ_W'(dg) * pcbe_pkg::SQ_W'(dg);
         sqb_ff    <= pcbe_pkg::SQ_W'(db) * pcbe_pkg::SQ_W'(db);
         sq_idx_ff <= cmd.entry;
      end
   end

   // Compare stage: keep the least distance, lowest index on ties
   logic [pcbe_pkg::DIST_W-1:0] sum_sq;
   logic [pcbe_pkg::DIST_W-1:0] best_ff;
   logic [pcbe_pkg::IDX_W-1:0]  best_idx_ff;
   assign sum_sq = pcbe_pkg::DIST_W'(sqr_ff) + pcbe_pkg::DIST_W'(sqg_ff)
                 + pcbe_pkg::DIST_W'(sqb_ff);

   always_ff @(posedge clock) begin
      if (sq_valid_ff && (sq_idx_ff == '0 || sum_sq < best_ff)) begin
         best_ff     <= sum_sq;
         best_idx_ff <= sq_idx_ff;
      end
   end

   // Index store, presence set and pixel counter
   logic [pcbe_pkg::IDX_W-1:0]    cell_idx_ff [pcbe_pkg::CELL_PIX];
   logic [pcbe_pkg::PAL_SIZE-1:0] present_ff;
   logic [pcbe_pkg::PIXCNT_W-1:0] pix_cnt_ff;
   logic [pcbe_pkg::IDX_W-1:0]    pix_idx;
   assign pix_idx = alt_hit ? alt_idx : best_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         cell_idx_ff[pix_cnt_ff] <= pix_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         pix_cnt_ff <= '0;
      end else begin
         if (cmd.store) begin
            present_ff <= present_ff | (pcbe_pkg::PAL_SIZE'(1) << pix_idx);
            pix_cnt_ff <= pix_cnt_ff + 1'b1;
         end else if (cmd.emit) begin
            present_ff <= '0;
         end
      end
   end

   assign status.last_pixel = (pix_cnt_ff == LAST_PIX);

   // Color scan: count colors and pick the first three non-background ones
   logic [pcbe_pkg::COUNT_W-1:0] count_ff;
   logic [1:0]                   slot_n_ff;
   logic [pcbe_pkg::IDX_W-1:0]   slot0_ff, slot1_ff, slot2_ff;
   logic                         scan_hit;
   assign scan_hit = present_ff[cmd.scan_color];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         slot_n_ff <= '0;
      end else if (cmd.emit) begin
         count_ff  <= '0;
         slot_n_ff <= '0;
      end else if (cmd.scan_en && scan_hit) begin
         count_ff <= count_ff + 1'b1;
         if (cmd.scan_color != bg_ff && slot_n_ff != 2'd3) begin
            slot_n_ff <= slot_n_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_en && scan_hit && cmd.scan_color != bg_ff) begin
         case (slot_n_ff)
            2'd0:    slot0_ff <= cmd.scan_color;
            2'd1:    slot1_ff <= cmd.scan_color;
            2'd2:    slot2_ff <= cmd.scan_color;
            default: ;
         endcase
      end
   end

   // Cell encoder: pad empty slots with the background
   logic [pcbe_pkg::IDX_W-1:0]  s0, s1, s2;
   logic [pcbe_pkg::ROWS_W-1:0] rows;
   logic                        fits;
   assign s0 = (slot_n_ff > 2'd0) ? slot0_ff : bg_ff;
   assign s1 = (slot_n_ff > 2'd1) ? slot1_ff : bg_ff;
   assign s2 = (slot_n_ff > 2'd2) ? slot2_ff : bg_ff;
   assign fits = present_ff[bg_ff] ? (count_ff <= pcbe_pkg::COUNT_W'(4))
                                   : (count_ff <= pcbe_pkg::COUNT_W'(3));

   always_comb begin
      rows = '0;
      for (int k = 0; k < pcbe_pkg::CELL_PIX; k++) begin
         if (cell_idx_ff[k] == bg_ff) begin
            rows[pcbe_pkg::ROWS_W-1-2*k -: 2] = pcbe_pkg::CODE_BG;
         end else if (cell_idx_ff[k] == s0) begin
            rows[pcbe_pkg::ROWS_W-1-2*k -: 2] = pcbe_pkg::CODE_SLOT0;
         end else if (cell_idx_ff[k] == s1) begin
            rows[pcbe_pkg::ROWS_W-1-2*k -: 2] = pcbe_pkg::CODE_SLOT1;
         end else if (cell_idx_ff[k] == s2) begin
            rows[pcbe_pkg::ROWS_W-1-2*k -: 2] = pcbe_pkg::CODE_SLOT2;
         end else begin
            rows[pcbe_pkg::ROWS_W-1-2*k -: 2] = pcbe_pkg::CODE_SLOT0;
         end
      end
   end

   // Output register
   logic                          out_valid_ff;
   logic [pcbe_pkg::ROWS_W-1:0]   out_rows_ff;
   logic [7:0]                    out_screen_ff;
   logic [3:0]                    out_color_ff;
   logic                          out_fits_ff;
   logic [pcbe_pkg::COUNT_W-1:0]  out_count_ff;

   assign status.out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_rows_ff   <= rows;
         out_screen_ff <= {s0, s1};
         out_color_ff  <= s2;
         out_fits_ff   <= fits;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bitmap_rows = out_rows_ff;
   assign rsp_screen_byte = out_screen_ff;
   assign rsp_color_byte  = out_color_ff;
   assign rsp_cell_fits   = out_fits_ff;
   assign rsp_color_count = out_count_ff;

endmodule

// ===== rtl/palette_cell_bitmap_encoder_core.sv =====
// Top level of the palette cell bitmap encoder: controller plus datapath.
//
// Usage: send the left pixel of each pixel pair of one 8x8 cell, 32 RGB requests in
// row order, on the req_ channel (valid/stall). Each pixel is mapped to a 16-entry
// palette index: variant table exact match first, else least squared distance.
// After the 32nd pixel one result appears on the rsp_ channel: bitmap rows, screen
// byte, color byte, fits flag and color count. Other pixels give no result.
// Pixels are taken one at a time: accept, one pass per palette entry through the shared
// squaring unit, a compare step, a store step; the palette search is the limit.
// After the 32nd pixel's store, a presence scan over the palette entries and the
// combinational encoder load the output register once it is free; rsp_valid comes
// from that register.
// csr_write_enable/csr_write_data set the background index; write only while idle.
// While the result waits under rsp_stall the next cell's pixels are still taken; a
// further cell result waits in the controller until the output register frees.
// Reset (synchronous, active high) clears background, presence set, pixel count
// and the output valid.
`timescale 1ns / 1ps

module palette_cell_bitmap_encoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pcbe_pkg::ROWS_W-1:0]  rsp_bitmap_rows,
   output logic [7:0]                   rsp_screen_byte,
   output logic [3:0]                   rsp_color_byte,
   output logic                         rsp_cell_fits,
   output logic [pcbe_pkg::COUNT_W-1:0] rsp_color_count,
   input  logic                         csr_write_enable,
   input  logic [3:0]                   csr_write_data
);

   pcbe_pkg::cmd_type    cmd;
   pcbe_pkg::status_type status;

   // Sequencer
   pcbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   pcbe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bitmap_rows  (rsp_bitmap_rows),
      .rsp_screen_byte  (rsp_screen_byte),
      .rsp_color_byte   (rsp_color_byte),
      .rsp_cell_fits    (rsp_cell_fits),
      .rsp_color_count  (rsp_color_count)
   );

endmodule

// ===== tb/palette_cell_checker.sv =====
// Cell result predictor and comparator for the palette cell bitmap encoder testbench.
`timescale 1ns / 1ps

module palette_cell_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [pcbe_pkg::ROWS_W-1:0]  rsp_bitmap_rows,
   input  logic [7:0]                   rsp_screen_byte,
   input  logic [3:0]                   rsp_color_byte,
   input  logic                         rsp_cell_fits,
   input  logic [pcbe_pkg::COUNT_W-1:0] rsp_color_count,
   input  logic                         csr_write_enable,
   input  logic [3:0]                   csr_write_data,
   output int                           mismatch_total,
   output int                           cells_outstanding
);

   typedef struct packed {
      logic [pcbe_pkg::ROWS_W-1:0]  rows;
      logic [7:0]                   screen;
      logic [3:0]                   color;
      logic                         fits;
      logic [pcbe_pkg::COUNT_W-1:0] count;
   } cell_result_type;

   localparam int PEND_DEPTH = 16;

   // Palette as {red, green, blue}
   localparam logic [23:0] PALETTE [16] = '{
      24'h000000, 24'hFFFFFF, 24'h68372B, 24'h70A4B2,
      24'h6F3D86, 24'h588D43, 24'h352879, 24'hB8C76F,
      24'h6F4F25, 24'h433900, 24'h9A6759, 24'h444444,
      24'h6C6C6C, 24'h9AD284, 24'h6C5EB5, 24'h959595
   };

   // Alternate shades that map directly to a palette entry
   localparam logic [23:0] VARIANT_RGB [8] = '{
      24'h70A4B2, 24'h7ABFC7, 24'hAAFFEE, 24'h99E6F9,
      24'h959595, 24'hABABAB, 24'hBBBBBB, 24'hD2D2D2
   };
   localparam logic [3:0] VARIANT_IDX [8] = '{
      4'd3, 4'd3, 4'd3, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15
   };

   logic [3:0]      background;
   logic [3:0]      pixel_index [32];
   logic [15:0]     color_seen;
   int              pixel_pos;
   int              fail_count;
   int              cells_checked;
   cell_result_type expected_cells [PEND_DEPTH];
   int              wr_count;
   int              rd_count;

   // Variant exact match wins; otherwise least squared distance, lowest index on a tie
   function automatic logic [3:0] nearest_palette_index(input logic [23:0] rgb);
      logic [3:0] best;
      int         best_sum, sq_sum, dr, dg, db, i;
      best = '0;
      best_sum = 0;
      for (i = 0; i < 16; i++) begin
         dr = int'(PALETTE[i][23:16]) - int'(rgb[23:16]);
         dg = int'(PALETTE[i][15:8]) - int'(rgb[15:8]);
         db = int'(PALETTE[i][7:0]) - int'(rgb[7:0]);
         sq_sum = dr * dr + dg * dg + db * db;
         if (i == 0 || sq_sum < best_sum) begin
            best_sum = sq_sum;
            best = i[3:0];
         end
      end
      for (i = 0; i < 8; i++)
         if (VARIANT_RGB[i] == rgb)
            best = VARIANT_IDX[i];
      return best;
   endfunction

   // Build the cell encoding from the stored indices and the presence set
   function automatic cell_result_type encode_cell(input logic [3:0] bg);
      cell_result_type res;
      logic [3:0]      slot [3];
      logic [1:0]      code;
      int              used, total, c, k;
      used = 0;
      total = 0;
      for (c = 0; c < 16; c++) begin
         if (color_seen[c]) begin
            total++;
            if (c[3:0] != bg && used < 3) begin
               slot[used] = c[3:0];
               used++;
            end
         end
      end
      // pad empty slots with the background
      while (used < 3) begin
         slot[used] = bg;
         used++;
      end
      res.rows = '0;
      for (k = 0; k < 32; k++) begin
         code = pcbe_pkg::CODE_BG;
         if (pixel_index[k] != bg) begin
            if (pixel_index[k] == slot[0])
               code = pcbe_pkg::CODE_SLOT0;
            else if (pixel_index[k] == slot[1])
               code = pcbe_pkg::CODE_SLOT1;
            else if (pixel_index[k] == slot[2])
               code = pcbe_pkg::CODE_SLOT2;
            else
               code = pcbe_pkg::CODE_SLOT0;  // color beyond the three slots
         end
         res.rows[63 - 2 * k -: 2] = code;
      end
      res.screen = {slot[0], slot[1]};
      res.color = slot[2];
      res.fits = color_seen[bg] ? (total <= 4) : (total <= 3);
      res.count = total[pcbe_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("cell %0d: %s is %h, predicted %h", cells_checked, what, got, want);
      fail_count++;
   endtask

   // Track config writes and requests, predict, and compare each accepted result
   always @(posedge clock) begin
      cell_result_type want;
      cell_result_type got;
      logic [3:0]      idx;
      if (reset) begin
         background = '0;
         color_seen = '0;
         pixel_pos = 0;
         wr_count = 0;
         rd_count = 0;
      end else begin
         if (csr_write_enable)
            background = csr_write_data;
         if (req_valid && !req_stall) begin
            idx = nearest_palette_index({req_red, req_green, req_blue});
            pixel_index[pixel_pos] = idx;
            color_seen[idx] = 1'b1;
            if (pixel_pos == 31) begin
               expected_cells[wr_count % PEND_DEPTH] = encode_cell(background);
               wr_count++;
               color_seen = '0;
               pixel_pos = 0;
            end else begin
               pixel_pos++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.rows = rsp_bitmap_rows;
            got.screen = rsp_screen_byte;
            got.color = rsp_color_byte;
            got.fits = rsp_cell_fits;
            got.count = rsp_color_count;
            if (wr_count == rd_count) begin
               report_mismatch("result with no cell pending", got.rows, '0);
            end else begin
               want = expected_cells[rd_count % PEND_DEPTH];
               rd_count++;
               if (got.rows !== want.rows)
                  report_mismatch("bitmap_rows", got.rows, want.rows);
               if (got.screen !== want.screen)
                  report_mismatch("screen_byte", 64'(got.screen), 64'(want.screen));
               if (got.color !== want.color)
                  report_mismatch("color_byte", 64'(got.color), 64'(want.color));
               if (got.fits !== want.fits)
                  report_mismatch("cell_fits", 64'(got.fits), 64'(want.fits));
               if (got.count !== want.count)
                  report_mismatch("color_count", 64'(got.count), 64'(want.count));
            end
            cells_checked++;
         end
      end
      mismatch_total <= fail_count;
      cells_outstanding <= wr_count - rd_count;
   end

endmodule

// ===== tb/palette_cell_bitmap_encoder_core_test.sv =====
// Top of the palette cell bitmap encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module palette_cell_bitmap_encoder_core_test;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [7:0]                   req_red = '0;
   logic [7:0]                   req_green = '0;
   logic [7:0]                   req_blue = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [pcbe_pkg::ROWS_W-1:0]  rsp_bitmap_rows;
   logic [7:0]                   rsp_screen_byte;
   logic [3:0]                   rsp_color_byte;
   logic                         rsp_cell_fits;
   logic [pcbe_pkg::COUNT_W-1:0] rsp_color_count;
   logic                         csr_write_enable = 1'b0;
   logic [3:0]                   csr_write_data = '0;
   int                           mismatch_total;
   int                           cells_outstanding;
   int                           max_wait = 5;

   // Odd colors for the directed cell: primaries, grays and near-tie points
   localparam logic [23:0] EXTRA_RGB [8] = '{
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
      24'h222222, 24'h7F7F7F, 24'hFEFEFE, 24'h010203
   };

   palette_cell_bitmap_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bitmap_rows  (rsp_bitmap_rows),
      .rsp_screen_byte  (rsp_screen_byte),
      .rsp_color_byte   (rsp_color_byte),
      .rsp_cell_fits    (rsp_cell_fits),
      .rsp_color_count  (rsp_color_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   palette_cell_checker cell_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bitmap_rows   (rsp_bitmap_rows),
      .rsp_screen_byte   (rsp_screen_byte),
      .rsp_color_byte    (rsp_color_byte),
      .rsp_cell_fits     (rsp_cell_fits),
      .rsp_color_count   (rsp_color_count),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_total    (mismatch_total),
      .cells_outstanding (cells_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Send one pixel request after a random gap; returns right after the accepting edge
   task automatic send_pixel(input logic [23:0] rgb);
      int gap;
      gap = $urandom_range(0, max_wait);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= rgb[23:16];
      req_green <= rgb[15:8];
      req_blue <= rgb[7:0];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Result side back-pressure: a random stall before each result
   initial begin
      int hold;
      while (reset)
         @(posedge clock);
      forever begin
         hold = $urandom_range(0, max_wait);
         repeat (hold) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   // Main sequence: phases of whole cells, background rewritten between phases
   initial begin
      logic [3:0]  bg;
      logic [3:0]  pick [6];
      logic [23:0] rgb;
      int          phase, cell_num, pix, c, ncol, style, mode, ch, v;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 10; phase++) begin
         if (phase == 0)
            bg = 4'd0;
         else if (phase == 1 || phase == 9)
            bg = 4'd15;
         else
            bg = 4'($urandom_range(0, 15));
         csr_write_enable <= 1'b1;
         csr_write_data <= bg;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         max_wait = (phase % 4 == 3) ? 0 : 5;

         // directed cell: every palette entry, every alternate shade, odd colors
         if (phase == 0) begin
            for (pix = 0; pix < 32; pix++) begin
               if (pix < 16)
                  rgb = pcbe_pkg::PAL_RGB[pix];
               else if (pix < 24)
                  rgb = pcbe_pkg::ALT_RGB[pix - 16];
               else
                  rgb = EXTRA_RGB[pix - 24];
               send_pixel(rgb);
            end
         end

         // random cells: a few colors per cell, rendered exact, as variant or jittered, some pixels fully random
         for (cell_num = 0; cell_num < 4; cell_num++) begin
            style = $urandom_range(0, 7);
            ncol = $urandom_range(1, 6);
            for (c = 0; c < 6; c++)
               pick[c] = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 2) != 0)
               pick[0] = bg;
            for (pix = 0; pix < 32; pix++) begin
               if (style == 0 || $urandom_range(0, 24) == 0) begin
                  rgb = 24'($urandom);
               end else begin
                  c = $urandom_range(0, ncol - 1);
                  rgb = pcbe_pkg::PAL_RGB[pick[c]];
                  mode = $urandom_range(0, 3);
                  if (mode == 2 && (pick[c] == 4'd3 || pick[c] == 4'd15)) begin
                     rgb = pcbe_pkg::ALT_RGB[(pick[c] == 4'd3 ? 0 : 4) + $urandom_range(0, 3)];
                  end else if (mode == 3) begin
                     for (ch = 0; ch < 3; ch++) begin
                        v = int'(rgb[ch * 8 +: 8]) + int'($urandom_range(0, 12)) - 6;
                        if (v < 0)
                           v = 0;
                        if (v > 255)
                           v = 255;
                        rgb[ch * 8 +: 8] = v[7:0];
                     end
                  end
               end
               send_pixel(rgb);
            end
         end

         // drain: all cell results in, then let the controller settle
         req_valid <= 1'b0;
         @(posedge clock);
         while (cells_outstanding != 0)
            @(posedge clock);
         repeat (40)
            @(posedge clock);
      end

      if (mismatch_total == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
